// ----- sv/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the settable clock display scanner
// Request kinds, reply codes, keypad codes and seven-segment decoding.
// ----------------------------------------------------------------------------
package scd_pkg;

  typedef enum logic [1:0] {
    KindSecond = 2'd0,
    KindScan   = 2'd1,
    KindKey    = 2'd2,
    KindSerial = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ReplyNone    = 2'd0,
    ReplyOk      = 2'd1,
    ReplyErr     = 2'd2,
    ReplyUnknown = 2'd3
  } reply_e;

  localparam logic [3:0] KeyNext = 4'd12;
  localparam logic [3:0] KeyRun  = 4'd14;
  localparam logic [3:0] KeyEdit = 4'd15;

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharT    = 8'h54;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [7:0]  SegBlank   = 8'hFF;
  localparam logic [7:0]  SegDash    = 8'hBF;
  localparam logic [15:0] BlinkReset = 16'd500;
  localparam logic [16:0] DaySeconds = 17'd86400;
  localparam logic [3:0]  FrameKeep  = 4'd7;
  localparam logic [3:0]  CountLimit = 4'd15;
  localparam int unsigned NumDigits  = 6;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic   valid;
    digit_t value;
  } key_digit_t;

  function automatic logic [7:0] seg_code(input digit_t d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

  function automatic key_digit_t key_digit(input logic [3:0] code);
    key_digit_t k;
    k.valid = 1'b1;
    unique case (code)
      4'd0:    k.value = 4'd1;
      4'd1:    k.value = 4'd2;
      4'd2:    k.value = 4'd3;
      4'd4:    k.value = 4'd4;
      4'd5:    k.value = 4'd5;
      4'd6:    k.value = 4'd6;
      4'd8:    k.value = 4'd7;
      4'd9:    k.value = 4'd8;
      4'd10:   k.value = 4'd9;
      4'd13:   k.value = 4'd0;
      default: begin
        k.valid = 1'b0;
        k.value = 4'd0;
      end
    endcase
    return k;
  endfunction

  // Reduces a digit value to the range of the given place.
  function automatic digit_t place_reduce(input digit_t d, input logic [2:0] pos);
    digit_t r;
    unique case (pos)
      3'd0: begin
        unique case (d)
          4'd3, 4'd4, 4'd5: r = d - 4'd3;
          4'd6, 4'd7, 4'd8: r = d - 4'd6;
          4'd9:             r = 4'd0;
          default:          r = d;
        endcase
      end
      3'd2, 3'd4: r = (d >= 4'd6) ? d - 4'd6 : d;
      default:    r = d;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] place_pos(input logic [2:0] pos);
    logic [2:0] p;
    unique case (pos)
      3'd0:    p = 3'd7;
      3'd1:    p = 3'd6;
      3'd2:    p = 3'd4;
      3'd3:    p = 3'd3;
      3'd4:    p = 3'd1;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] next_edit_pos(input logic [2:0] pos);
    logic [2:0] n;
    unique case (pos)
      3'd5:    n = 3'd0;
      3'd6:    n = 3'd1;
      3'd7:    n = 3'd2;
      default: n = pos + 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic is_digit_char(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

endpackage

// ----- sv/settable_clock_display_scanner.sv -----
// ----------------------------------------------------------------------------
// settable_clock_display_scanner: time-of-day clock with display scanner
// Second ticks, scan ticks, keypad codes and serial bytes each produce one
// result with the scanned segment pattern, a serial reply and the time.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its input is not stalled
// and returns one result per request: a request is captured in an input
// register, processed in a single pass, and stored in the result register.
// The time is kept as six decimal digits, so every update is a short digit
// operation. A stalled result holds the result register, and the input side
// stalls only while both registers are full.
module settable_clock_display_scanner
  import scd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  key_code_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  segments_o,
  output logic [7:0]  digit_select_o,
  output logic [1:0]  reply_o,
  output logic [16:0] time_of_day_o,
  output logic        editing_o
);

  localparam int unsigned CapRaw = (LINE_BYTES - 1 < 15) ? LINE_BYTES - 1 : 15;
  localparam logic [3:0]  FrameCap = 4'(CapRaw);

  logic        in_vld_q;
  logic [1:0]  kind_q;
  logic [3:0]  key_q;
  logic [7:0]  rx_q;
  logic        advance, fire;

  logic [15:0] period_q;
  digit_t      digits_q [NumDigits];
  digit_t      digits_d [NumDigits];
  logic        edit_q, edit_d;
  logic [2:0]  pos_q, pos_d;
  logic [2:0]  scan_q, scan_d;
  logic [15:0] blink_q, blink_d;
  logic        vis_q, vis_d;
  logic        pat_valid_q;
  logic        refresh;
  logic [7:0]  frame_q [FrameKeep];
  logic [3:0]  len_q, len_d;
  logic        frame_we;

  logic [7:0]  seg_d, sel_d;
  reply_e      reply_d;
  logic [16:0] tod_d;
  logic [16:0] blink_sum;
  key_digit_t  kd;
  logic        digits_ok;

  logic        out_valid_q;
  logic [7:0]  seg_q, sel_q;
  logic [1:0]  reply_q;
  logic [16:0] tod_q;
  logic        editing_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q <= kind_i;
      key_q  <= key_code_i;
      rx_q   <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= BlinkReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      digits_d[i] = digits_q[i];
    end
    edit_d    = edit_q;
    pos_d     = pos_q;
    scan_d    = scan_q;
    blink_d   = blink_q;
    vis_d     = vis_q;
    len_d     = len_q;
    frame_we  = 1'b0;
    refresh   = 1'b0;
    seg_d     = SegBlank;
    sel_d     = 8'd0;
    reply_d   = ReplyNone;
    blink_sum = {1'b0, blink_q} + 17'd1;
    kd        = key_digit(key_q);
    digits_ok = 1'b1;
    for (int i = 1; i < 7; i++) begin
      digits_ok = digits_ok && is_digit_char(frame_q[i]);
    end

    unique case (kind_e'(kind_q))
      KindSecond: begin
        if (!edit_q) begin
          refresh = 1'b1;
          if (digits_q[5] != 4'd9) begin
            digits_d[5] = digits_q[5] + 4'd1;
          end else begin
            digits_d[5] = 4'd0;
            if (digits_q[4] != 4'd5) begin
              digits_d[4] = digits_q[4] + 4'd1;
            end else begin
              digits_d[4] = 4'd0;
              if (digits_q[3] != 4'd9) begin
                digits_d[3] = digits_q[3] + 4'd1;
              end else begin
                digits_d[3] = 4'd0;
                if (digits_q[2] != 4'd5) begin
                  digits_d[2] = digits_q[2] + 4'd1;
                end else begin
                  digits_d[2] = 4'd0;
                  if (digits_q[0] == 4'd2 && digits_q[1] == 4'd3) begin
                    digits_d[0] = 4'd0;
                    digits_d[1] = 4'd0;
                  end else if (digits_q[1] == 4'd9) begin
                    digits_d[0] = digits_q[0] + 4'd1;
                    digits_d[1] = 4'd0;
                  end else begin
                    digits_d[1] = digits_q[1] + 4'd1;
                  end
                end
              end
            end
          end
        end
      end
      KindScan: begin
        if (pat_valid_q) begin
          unique case (scan_q)
            3'd7:    seg_d = seg_code(digits_q[0]);
            3'd6:    seg_d = seg_code(digits_q[1]);
            3'd4:    seg_d = seg_code(digits_q[2]);
            3'd3:    seg_d = seg_code(digits_q[3]);
            3'd1:    seg_d = seg_code(digits_q[4]);
            3'd0:    seg_d = seg_code(digits_q[5]);
            default: seg_d = SegDash;
          endcase
        end
        if (edit_q && scan_q == place_pos(pos_q) && !vis_q) begin
          seg_d = SegBlank;
        end
        sel_d  = 8'd1 << scan_q;
        scan_d = scan_q + 3'd1;
        if (blink_sum >= {1'b0, period_q}) begin
          blink_d = 16'd0;
          vis_d   = !vis_q;
        end else begin
          blink_d = blink_sum[15:0];
        end
      end
      KindKey: begin
        refresh = 1'b1;
        priority if (key_q == KeyRun) begin
          edit_d = 1'b0;
        end else if (key_q == KeyEdit) begin
          edit_d = 1'b1;
        end else if (key_q == KeyNext) begin
          pos_d = next_edit_pos(pos_q);
        end else if (kd.valid && pos_q < 3'(NumDigits)) begin
          digits_d[pos_q] = place_reduce(kd.value, pos_q);
          if (digits_d[0] == 4'd2 && digits_d[1] >= 4'd4) begin
            digits_d[0] = 4'd0;
            digits_d[1] = digits_d[1] - 4'd4;
          end
        end
      end
      KindSerial: begin
        if (rx_q == CharCr || rx_q == CharLf) begin
          len_d = 4'd0;
          if (len_q != 4'd0) begin
            priority if (len_q < FrameKeep || frame_q[0] != CharT) begin
              reply_d = ReplyUnknown;
            end else if (!digits_ok) begin
              reply_d = ReplyErr;
            end else if (frame_q[1][3:0] > 4'd2
                         || (frame_q[1][3:0] == 4'd2 && frame_q[2][3:0] > 4'd3)
                         || frame_q[3][3:0] > 4'd5
                         || frame_q[5][3:0] > 4'd5) begin
              reply_d = ReplyErr;
            end else begin
              reply_d = ReplyOk;
              refresh = 1'b1;
              for (int i = 0; i < NumDigits; i++) begin
                digits_d[i] = frame_q[i + 1][3:0];
              end
            end
          end
        end else begin
          frame_we = len_q < FrameKeep;
          if (len_q < FrameCap) begin
            len_d = len_q + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase

    tod_d = 17'(digits_d[0]) * 17'd36000 + 17'(digits_d[1]) * 17'd3600
          + 17'(digits_d[2]) * 17'd600 + 17'(digits_d[3]) * 17'd60
          + 17'(digits_d[4]) * 17'd10 + 17'(digits_d[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        digits_q[i] <= 4'd0;
      end
      edit_q      <= 1'b0;
      pos_q       <= 3'd0;
      scan_q      <= 3'd0;
      blink_q     <= 16'd0;
      vis_q       <= 1'b1;
      pat_valid_q <= 1'b0;
      len_q       <= 4'd0;
    end else if (fire) begin
      for (int i = 0; i < NumDigits; i++) begin
        digits_q[i] <= digits_d[i];
      end
      edit_q  <= edit_d;
      pos_q   <= pos_d;
      scan_q  <= scan_d;
      blink_q <= blink_d;
      vis_q   <= vis_d;
      len_q   <= len_d;
      if (refresh) begin
        pat_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && frame_we) begin
      frame_q[len_q[2:0]] <= rx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      seg_q     <= seg_d;
      sel_q     <= sel_d;
      reply_q   <= reply_d;
      tod_q     <= tod_d;
      editing_q <= edit_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = seg_q;
  assign digit_select_o = sel_q;
  assign reply_o        = reply_q;
  assign time_of_day_o  = tod_q;
  assign editing_o      = editing_q;

`ifndef ASSERT_OFF
  a_select_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(digit_select_o))
    else $error("digit select is not one-hot");

  a_reply_not_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_o != ReplyNone |-> digit_select_o == 8'd0)
    else $error("reply given on a scan result");

  a_time_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> time_of_day_o < DaySeconds)
    else $error("time of day out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_edit_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < 3'(NumDigits))
    else $error("edit position out of range");
`endif

endmodule

// ----- dv/settable_clock_display_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// settable_clock_display_scanner_tb: self-checking bench for the clock scanner
// A short table of directed requests is followed by random ticks, keys and
// serial frames under four blink settings, with random gaps on both sides.
// Every result is compared with a bit-accurate model of the clock or, for a directed row, its table entry.
// ----------------------------------------------------------------------------
module settable_clock_display_scanner_tb;
  import scd_pkg::*;

  localparam int LineBytes = 16;
  localparam int FrameCap = (LineBytes - 1 < CountLimit) ? LineBytes - 1 : CountLimit;
  localparam int PhaseRequests = 400;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [7:0]  seg;
    logic [7:0]  sel;
    reply_e      reply;
    logic [16:0] tod;
    logic        editing;
  } display_result_t;

  typedef struct {
    kind_e           kind;
    logic [3:0]      key;
    logic [7:0]      rx;
    bit              known;
    display_result_t want;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  kind_e       req_kind = KindSecond;
  logic [3:0]  req_key = '0;
  logic [7:0]  req_rx = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  segments;
  logic [7:0]  digit_select;
  logic [1:0]  reply;
  logic [16:0] time_of_day;
  logic        editing;

  settable_clock_display_scanner #(
    .LINE_BYTES(LineBytes)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (req_kind),
    .key_code_i    (req_key),
    .rx_byte_i     (req_rx),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .segments_o    (segments),
    .digit_select_o(digit_select),
    .reply_o       (reply),
    .time_of_day_o (time_of_day),
    .editing_o     (editing)
  );

  int weight_of [6] = '{36000, 3600, 600, 60, 10, 1};
  int limit_of [6] = '{3, 10, 6, 10, 6, 10};
  int lamp_of [6] = '{7, 6, 4, 3, 1, 0};
  int digit_of_key [16] = '{1, 2, 3, -1, 4, 5, 6, -1, 7, 8, 9, -1, -1, 0, -1, -1};

  int          clock_secs;
  bit          edit_on;
  int          edit_place;
  logic [2:0]  scan_pos;
  logic [15:0] blink_ticks;
  bit          blink_lit;
  logic [15:0] blink_period;
  logic [7:0]  shown [8];
  logic [7:0]  frame_buf [7];
  int          frame_len;

  display_result_t display_due [$];
  request_row_t    plan [$];
  int requests_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int frames_ok = 0;
  int frames_err = 0;
  int frames_unknown = 0;
  int blink_blanks = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run timed out after %0d cycles.", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] glyph(input int d);
    case (d)
      0: return 8'hC0;
      1: return 8'hF9;
      2: return 8'hA4;
      3: return 8'hB0;
      4: return 8'h99;
      5: return 8'h92;
      6: return 8'h82;
      7: return 8'hF8;
      8: return 8'h80;
      9: return 8'h90;
      default: return SegBlank;
    endcase
  endfunction

  function automatic int digit_at(input int place);
    int h, m, s;
    h = clock_secs / 3600;
    m = (clock_secs / 60) % 60;
    s = clock_secs % 60;
    case (place)
      0: return h / 10;
      1: return h % 10;
      2: return m / 10;
      3: return m % 10;
      4: return s / 10;
      default: return s % 10;
    endcase
  endfunction

  function automatic void redraw_digits();
    shown[7] = glyph(digit_at(0));
    shown[6] = glyph(digit_at(1));
    shown[5] = SegDash;
    shown[4] = glyph(digit_at(2));
    shown[3] = glyph(digit_at(3));
    shown[2] = SegDash;
    shown[1] = glyph(digit_at(4));
    shown[0] = glyph(digit_at(5));
  endfunction

  function automatic reply_e close_frame();
    int hh, mm, ss, i;
    if (frame_len < FrameKeep || frame_buf[0] != CharT) begin
      frames_unknown++;
      return ReplyUnknown;
    end
    for (i = 1; i < FrameKeep; i++) begin
      if (frame_buf[i] < CharZero || frame_buf[i] > CharNine) begin
        frames_err++;
        return ReplyErr;
      end
    end
    hh = int'(frame_buf[1] - CharZero) * 10 + int'(frame_buf[2] - CharZero);
    mm = int'(frame_buf[3] - CharZero) * 10 + int'(frame_buf[4] - CharZero);
    ss = int'(frame_buf[5] - CharZero) * 10 + int'(frame_buf[6] - CharZero);
    if (hh > 23 || mm > 59 || ss > 59) begin
      frames_err++;
      return ReplyErr;
    end
    clock_secs = hh * 3600 + mm * 60 + ss;
    redraw_digits();
    frames_ok++;
    return ReplyOk;
  endfunction

  function automatic display_result_t predict_display(input kind_e kind,
                                                      input logic [3:0] key,
                                                      input logic [7:0] rx);
    display_result_t r;
    int place, d;
    logic [16:0] count_next;
    r.seg = SegBlank;
    r.sel = '0;
    r.reply = ReplyNone;
    case (kind)
      KindSecond: begin
        if (!edit_on) begin
          clock_secs = (clock_secs + 1) % 86400;
          redraw_digits();
        end
      end
      KindScan: begin
        r.seg = shown[scan_pos];
        if (edit_on && scan_pos == lamp_of[edit_place] && !blink_lit) begin
          r.seg = SegBlank;
          blink_blanks++;
        end
        r.sel = 8'd1 << scan_pos;
        scan_pos = scan_pos + 3'd1;
        count_next = {1'b0, blink_ticks} + 17'd1;
        if (count_next >= {1'b0, blink_period}) begin
          count_next = '0;
          blink_lit = !blink_lit;
        end
        blink_ticks = count_next[15:0];
      end
      KindKey: begin
        place = edit_place;
        d = digit_of_key[key];
        if (key == KeyRun) begin
          edit_on = 1'b0;
        end else if (key == KeyEdit) begin
          edit_on = 1'b1;
        end else if (key == KeyNext) begin
          edit_place = (place + 1) % 6;
        end else if (d >= 0) begin
          clock_secs = (clock_secs - weight_of[place] * digit_at(place)
                        + weight_of[place] * (d % limit_of[place])) % 86400;
        end
        redraw_digits();
      end
      KindSerial: begin
        if (rx == CharCr || rx == CharLf) begin
          if (frame_len != 0) r.reply = close_frame();
          frame_len = 0;
        end else begin
          if (frame_len < FrameKeep) frame_buf[frame_len] = rx;
          if (frame_len < FrameCap) frame_len++;
        end
      end
    endcase
    r.tod = clock_secs[16:0];
    r.editing = edit_on;
    return r;
  endfunction

  function automatic void add_row(input kind_e kind, input logic [3:0] key,
                                  input logic [7:0] rx);
    request_row_t row;
    row.kind = kind;
    row.key = key;
    row.rx = rx;
    row.known = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_known(input kind_e kind, input logic [3:0] key,
                                    input logic [7:0] rx, input logic [7:0] seg,
                                    input logic [7:0] sel, input reply_e rep,
                                    input int tod, input bit ed);
    request_row_t row;
    row.kind = kind;
    row.key = key;
    row.rx = rx;
    row.known = 1'b1;
    row.want = '{seg, sel, rep, 17'(tod), ed};
    plan.push_back(row);
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_row(KindSerial, 4'd0, s[i]);
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CharCr || c == CharLf) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [3:0] pick_key();
    case ($urandom_range(0, 9))
      0: return KeyEdit;
      1: return KeyRun;
      2: return KeyNext;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic offer(input kind_e kind, input logic [3:0] key, input logic [7:0] rx,
                       input bit known = 1'b0, input display_result_t want = '0);
    int gap;
    display_result_t model;
    gap = (((requests_sent / 40) % 5) == 2) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_kind <= kind;
    req_key <= key;
    req_rx <= rx;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    model = predict_display(kind, key, rx);
    display_due.push_back(known ? want : model);
    requests_sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (display_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_blink_period(input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    blink_period = value;
  endtask

  task automatic send_frame();
    logic [7:0] text [$];
    int parts [3];
    int style, n, i;
    style = $urandom_range(0, 9);
    parts[0] = $urandom_range(0, 23);
    parts[1] = $urandom_range(0, 59);
    parts[2] = $urandom_range(0, 59);
    if (style == 6) begin
      n = $urandom_range(0, 2);
      parts[n] = (n == 0) ? $urandom_range(24, 99) : $urandom_range(60, 99);
    end
    text.push_back(CharT);
    for (i = 0; i < 3; i++) begin
      text.push_back(CharZero + 8'(parts[i] / 10));
      text.push_back(CharZero + 8'(parts[i] % 10));
    end
    if (style == 7) begin
      text[$urandom_range(1, 6)] = stray_byte();
    end else if (style == 8) begin
      if ($urandom_range(0, 1) == 1) begin
        text[0] = stray_byte();
      end else begin
        n = $urandom_range(1, 6);
        while (text.size() > n) void'(text.pop_back());
      end
    end else if (style == 9) begin
      repeat ($urandom_range(1, 12)) text.push_back(stray_byte());
    end
    foreach (text[i]) offer(KindSerial, 4'($urandom), text[i]);
    offer(KindSerial, 4'($urandom), ($urandom_range(0, 1) == 1) ? CharCr : CharLf);
    if ($urandom_range(0, 7) == 0) offer(KindSerial, 4'($urandom), CharCr);
  endtask

  task automatic random_phase(input int count);
    int goal, pick;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        offer(KindScan, 4'($urandom), 8'($urandom));
      end else if (pick < 50) begin
        offer(KindSecond, 4'($urandom), 8'($urandom));
      end else if (pick < 70) begin
        offer(KindKey, pick_key(), 8'($urandom));
      end else if (pick < 95) begin
        send_frame();
      end else begin
        offer(KindSerial, 4'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  initial begin : result_sink
    int hold;
    display_result_t want;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (results_checked == 300 || results_checked == 1000) begin
        hold = 80;
      end else if (((results_checked / 50) % 5) == 4) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      if (display_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none, actual time %0d",
                 $time, time_of_day);
      end else begin
        want = display_due.pop_front();
        compare_field("segments", want.seg, segments);
        compare_field("digit_select", want.sel, digit_select);
        compare_field("reply", want.reply, reply);
        compare_field("time_of_day", want.tod, time_of_day);
        compare_field("editing", want.editing, editing);
      end
      results_checked++;
      @(posedge clk);
    end
  end

  initial begin : request_source
    int i;
    clock_secs = 0;
    edit_on = 1'b0;
    edit_place = 0;
    scan_pos = '0;
    blink_ticks = '0;
    blink_lit = 1'b1;
    blink_period = BlinkReset;
    frame_len = 0;
    for (i = 0; i < 8; i++) shown[i] = SegBlank;
    for (i = 0; i < FrameKeep; i++) frame_buf[i] = '0;

    add_known(KindScan, 4'd0, 8'd0, SegBlank, 8'h01, ReplyNone, 0, 1'b0);
    add_known(KindSecond, 4'd0, 8'd0, SegBlank, 8'h00, ReplyNone, 1, 1'b0);
    add_known(KindSerial, 4'd0, CharLf, SegBlank, 8'h00, ReplyNone, 1, 1'b0);
    add_text("T235959");
    add_known(KindSerial, 4'd0, CharCr, SegBlank, 8'h00, ReplyOk, 86399, 1'b0);
    add_known(KindSecond, 4'd0, 8'd0, SegBlank, 8'h00, ReplyNone, 0, 1'b0);
    add_known(KindKey, KeyEdit, 8'd0, SegBlank, 8'h00, ReplyNone, 0, 1'b1);
    add_known(KindKey, KeyEdit, 8'd0, SegBlank, 8'h00, ReplyNone, 0, 1'b1);
    add_known(KindSecond, 4'd0, 8'd0, SegBlank, 8'h00, ReplyNone, 0, 1'b1);
    add_row(KindKey, 4'd2, 8'd0);
    add_row(KindKey, 4'd1, 8'd0);
    add_row(KindScan, 4'd0, 8'd0);
    add_row(KindKey, KeyNext, 8'd0);
    add_row(KindKey, 4'd10, 8'd0);
    add_row(KindKey, 4'd3, 8'd0);
    add_row(KindKey, KeyRun, 8'd0);
    add_row(KindKey, KeyRun, 8'd0);
    add_row(KindKey, 4'd13, 8'd0);
    add_row(KindSecond, 4'd15, 8'hFF);
    add_text("X");
    add_row(KindSerial, 4'd0, CharCr);
    add_text("T");
    add_row(KindSerial, 4'd0, CharLf);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i].kind, plan[i].key, plan[i].rx, plan[i].known, plan[i].want);
    drain();
    set_blink_period(16'd1);
    random_phase(PhaseRequests);
    drain();
    set_blink_period(16'($urandom_range(2, 12)));
    random_phase(PhaseRequests);
    drain();
    set_blink_period(16'hFFFF);
    random_phase(PhaseRequests);
    drain();
    set_blink_period(16'($urandom_range(13, 600)));
    random_phase(PhaseRequests);
    drain();

    $display("Checked %0d results for %0d requests under five blink half periods.",
             results_checked, requests_sent);
    $display("Serial frames: %0d OK, %0d ERR, %0d unknown; %0d scans blanked the edited digit.",
             frames_ok, frames_err, frames_unknown, blink_blanks);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
